// ----- design/cjk_pkg.sv -----
// ----------------------------------------------------------------------------
// cjk_pkg
// shared types and constants for the chinese character byte filter
// ----------------------------------------------------------------------------
package cjk_pkg;

    // byte ranges of the two encodings
    localparam logic [7:0] GB_LEAD_LO        = 8'hA1;
    localparam logic [7:0] GB_LEAD_HI        = 8'hF7;
    localparam logic [7:0] GB_TRAIL_LO       = 8'hA1;
    localparam logic [7:0] GB_TRAIL_HI       = 8'hFE;
    localparam logic [7:0] U8_LEAD_LO        = 8'hE4;
    localparam logic [7:0] U8_LEAD_HI        = 8'hE9;
    localparam logic [7:0] U8_E4_SECOND_MIN  = 8'hB8;
    localparam logic [7:0] U8_E4B8_THIRD_MIN = 8'h80;
    localparam logic [7:0] U8_E9_SECOND_MAX  = 8'hBF;
    localparam logic [7:0] U8_E9BF_THIRD_MAX = 8'hBF;
    localparam logic [1:0] BOM_LEN           = 2'd3;

    // results per byte and output queue sizing
    localparam int MAX_RESULTS = 3;
    localparam int RES_W       = 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LEAD   = 2'd1,
        PH_SECOND = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CHK_NONE = 2'd0,
        CHK_MIN  = 2'd1,
        CHK_MAX  = 2'd2
    } t_check;

    typedef struct packed {
        logic [1:0] skip;
        t_phase     phase;
        t_check     check;
        logic [7:0] held1;
        logic [7:0] held2;
    } t_seq_state;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       char_last;
    } t_item;

    typedef struct packed {
        t_seq_state                   nxt;
        logic [RES_W-1:0]             cnt;
        t_item [MAX_RESULTS-1:0]      items;
    } t_step;

endpackage

// ----- design/cjk_decode.sv -----
// ----------------------------------------------------------------------------
// cjk_decode
// next sequence state and emitted bytes for one input byte
// ----------------------------------------------------------------------------
module cjk_decode
    import cjk_pkg::*;
(
    input  logic       i_utf8_mode,
    input  t_seq_state i_st,
    input  logic [7:0] i_byte,
    input  logic       i_seg_end,
    output t_step      o_step
);

    always_comb begin
        logic       gb_path;
        logic       u8_path;
        logic       ok;
        t_seq_state n;
        logic [RES_W-1:0] cnt;
        t_item [MAX_RESULTS-1:0] items;

        n       = i_st;
        cnt     = '0;
        items   = '0;
        gb_path = !i_utf8_mode;
        u8_path = i_utf8_mode && (i_st.skip == 2'd0);
        ok      = 1'b1;

        // order mark counter runs in both modes
        if (i_st.skip != 2'd0) begin
            n.skip = i_st.skip - 2'd1;
        end

        // gb2312 lead/trail pairs
        if (gb_path) begin
            n.phase = PH_IDLE;
            if (i_st.phase == PH_LEAD) begin
                if (i_byte >= GB_TRAIL_LO && i_byte <= GB_TRAIL_HI) begin
                    items[0] = '{char_byte: i_st.held1, char_last: 1'b0};
                    items[1] = '{char_byte: i_byte,     char_last: 1'b1};
                    cnt      = RES_W'(2);
                end
            end else if (i_byte >= GB_LEAD_LO && i_byte <= GB_LEAD_HI) begin
                n.held1 = i_byte;
                n.phase = PH_LEAD;
            end
        end

        // utf-8 three byte sequences
        if (u8_path) begin
            case (i_st.phase)
                PH_LEAD: begin
                    n.phase = PH_SECOND;
                    n.check = CHK_NONE;
                    n.held2 = i_byte;
                    if (i_st.held1 == U8_LEAD_LO) begin
                        if (i_byte < U8_E4_SECOND_MIN) begin
                            n.phase = PH_IDLE;
                        end else if (i_byte == U8_E4_SECOND_MIN) begin
                            n.check = CHK_MIN;
                        end
                    end else if (i_st.held1 == U8_LEAD_HI) begin
                        if (i_byte > U8_E9_SECOND_MAX) begin
                            n.phase = PH_IDLE;
                        end else if (i_byte == U8_E9_SECOND_MAX) begin
                            n.check = CHK_MAX;
                        end
                    end
                end
                PH_SECOND: begin
                    if (i_st.check == CHK_MIN && i_byte < U8_E4B8_THIRD_MIN) begin
                        ok = 1'b0;
                    end
                    if (i_st.check == CHK_MAX && i_byte > U8_E9BF_THIRD_MAX) begin
                        ok = 1'b0;
                    end
                    n.phase = PH_IDLE;
                    n.check = CHK_NONE;
                    if (ok) begin
                        items[0] = '{char_byte: i_st.held1, char_last: 1'b0};
                        items[1] = '{char_byte: i_st.held2, char_last: 1'b0};
                        items[2] = '{char_byte: i_byte,     char_last: 1'b1};
                        cnt      = RES_W'(3);
                    end
                end
                default: begin
                    // idle, and the unused phase code behaves as idle
                    n.phase = PH_IDLE;
                    n.check = CHK_NONE;
                    if (i_byte >= U8_LEAD_LO && i_byte <= U8_LEAD_HI) begin
                        n.held1 = i_byte;
                        n.phase = PH_LEAD;
                    end
                end
            endcase
        end

        // segment end drops any partial sequence
        if (i_seg_end) begin
            n.phase = PH_IDLE;
            n.check = CHK_NONE;
            n.skip  = BOM_LEN;
        end

        o_step = '{nxt: n, cnt: cnt, items: items};
    end

endmodule

// ----- design/cjk_out_fifo.sv -----
// ----------------------------------------------------------------------------
// cjk_out_fifo
// result queue taking up to three bytes per cycle, draining one per cycle while popped
// ----------------------------------------------------------------------------
module cjk_out_fifo
    import cjk_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [RES_W-1:0]        i_push_cnt,
    input  t_item [MAX_RESULTS-1:0] i_push_items,
    input  logic                    i_pop,
    output t_item                   o_head,
    output logic [CNT_W-1:0]        o_count
);

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;

    // pointer and fill arithmetic
    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push_cnt);
        n_rd    = i_pop ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(i_pop);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage, written at consecutive slots
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RES_W'(k) < i_push_cnt) begin
                r_mem[r_wr + PTR_W'(k)] <= i_push_items[k];
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

// ----- design/cjk_byte_extractor.sv -----
// ----------------------------------------------------------------------------
// cjk_byte_extractor
// passes on only the chinese character byte sequences of a segmented stream
// ----------------------------------------------------------------------------
// results: a completing byte's results are registered into the result queue
// throughput: one input byte and, while the receiver is ready, one result byte
//   per cycle; input stalls only when fewer than three of eight slots are free
// reset: synchronous active low; gb2312 mode, idle phase, order mark count 3,
//   result queue empty
module cjk_byte_extractor
    import cjk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: utf8_mode
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // segment_end
    // result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] char_byte
    output logic       m_axis_tlast    // char_last
);

    logic             r_mode;
    t_seq_state       r_st;
    t_step            step;
    t_item            head;
    logic [CNT_W-1:0] count;
    logic             s_acc;
    logic             cfg_acc;
    logic             pop;
    logic [RES_W-1:0] push_cnt;

    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid;
    assign s_axis_tready = (count <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign push_cnt      = s_acc ? step.cnt : '0;

    cjk_decode u_decode (
        .i_utf8_mode (r_mode),
        .i_st        (r_st),
        .i_byte      (s_axis_tdata),
        .i_seg_end   (s_axis_tlast),
        .o_step      (step)
    );

    cjk_out_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cnt   (push_cnt),
        .i_push_items (step.items),
        .i_pop        (pop),
        .o_head       (head),
        .o_count      (count)
    );

    // mode register and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_st   <= '{skip: BOM_LEN, phase: PH_IDLE, check: CHK_NONE,
                        held1: 8'h00, held2: 8'h00};
        end else if (cfg_acc) begin
            r_mode     <= i_cfg_data;
            r_st.phase <= PH_IDLE;
            r_st.check <= CHK_NONE;
        end else if (s_acc) begin
            r_st <= step.nxt;
        end
    end

    assign m_axis_tvalid = (count != '0);
    assign m_axis_tdata  = head.char_byte;
    assign m_axis_tlast  = head.char_last;

    // queue never overfills
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // order mark bytes in utf-8 mode never emit
    a_bom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !cfg_acc && r_mode && r_st.skip != 2'd0) |-> (step.cnt == '0))
        else $error("order mark byte emitted");

    // segment end returns to a fresh segment
    a_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !cfg_acc && s_axis_tlast) |=>
            (r_st.phase == PH_IDLE && r_st.skip == BOM_LEN && r_st.check == CHK_NONE))
        else $error("segment end left sequence state");

    // the final byte of an emitted run is flagged last
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && step.cnt != '0) |-> step.items[step.cnt - RES_W'(1)].char_last)
        else $error("emitted run without last flag");

endmodule

// ----- tb/sv/tb_cjk_byte_extractor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cjk_byte_extractor
// self-checking bench for the chinese character byte filter: a directed table
// in both encodings, then random segments of well-formed, broken and noise
// sequences under random idling and one long result hold-off per encoding;
// each result byte is checked against its row or a behavioral predictor of the filter
// ----------------------------------------------------------------------------
module tb_cjk_byte_extractor
    import cjk_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 73;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIR_ROWS      = 25;

    // values of the utf8_mode register
    localparam logic MODE_GB   = 1'b0;
    localparam logic MODE_UTF8 = 1'b1;

    // utf-8 byte order mark
    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;

    typedef struct packed {
        logic [7:0] cbyte;
        logic       clast;
    } t_char_out;

    typedef struct packed {
        logic [7:0] data;
        logic       seg_end;
    } t_byte_in;

    // one directed request; typed rows carry their results, others use the predictor
    typedef struct packed {
        logic       mode;
        logic [7:0] data;
        logic       seg_end;
        logic       typed;
        logic [1:0] n_chars;
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
    } t_dir_row;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // gb2312 right after reset: pairs at the range edges, drops, open lead at end
        '{MODE_GB,   8'hA1, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_GB,   8'hFE, 1'b0, 1'b1, 2'd2, 8'hA1, 8'hFE, 8'h00},
        '{MODE_GB,   8'hF7, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_GB,   8'hA1, 1'b0, 1'b1, 2'd2, 8'hF7, 8'hA1, 8'h00},
        '{MODE_GB,   8'hF8, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_GB,   8'hA0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_GB,   8'hB0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_GB,   8'h00, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_GB,   8'hC0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        // utf-8: order mark skipped, bound checks pass and fail, unchecked lead
        '{MODE_UTF8, 8'hEF, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hBB, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hBF, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hE4, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hB8, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'h80, 1'b0, 1'b1, 2'd3, 8'hE4, 8'hB8, 8'h80},
        '{MODE_UTF8, 8'hE9, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hBF, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hBF, 1'b0, 1'b1, 2'd3, 8'hE9, 8'hBF, 8'hBF},
        '{MODE_UTF8, 8'hE4, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hB7, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hE9, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hC0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hE5, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_UTF8, 8'hFF, 1'b1, 1'b1, 2'd3, 8'hE5, 8'h00, 8'hFF}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic       s_axis_tlast;   // segment_end
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] char_byte
    logic       m_axis_tlast;   // char_last

    // predictor state
    logic       pr_mode   = MODE_GB;
    logic [1:0] pr_skip   = BOM_LEN;
    t_phase     pr_phase  = PH_IDLE;
    t_check     pr_check  = CHK_NONE;
    logic [7:0] pr_lead   = 8'h00;
    logic [7:0] pr_second = 8'h00;

    t_char_out  step_chars[$];
    t_char_out  pending_chars[$];
    t_byte_in   seg_plan[$];

    int   cycle_cnt      = 0;
    int   mismatch_cnt   = 0;
    int   rx_hold_cycles = 0;
    logic tx_idle        = 1'b1;
    logic rx_idle        = 1'b1;

    cjk_byte_extractor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL cjk_byte_extractor");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [8:0] want,
                                   input logic [8:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
            $display("mismatch %s: expected %h actual %h at cycle %0d",
                     what, want, got, cycle_cnt);
    endtask

    task automatic emit_char(input logic [7:0] b, input logic last);
        t_char_out c;
        c.cbyte = b;
        c.clast = last;
        step_chars = {step_chars, c};
    endtask

    // gb2312: lead A1..F7, any next byte is its trail, pair kept if trail in A1..FE
    task automatic gb_step(input logic [7:0] b);
        if (pr_phase == PH_LEAD) begin
            pr_phase = PH_IDLE;
            if (b >= GB_TRAIL_LO && b <= GB_TRAIL_HI) begin
                emit_char(pr_lead, 1'b0);
                emit_char(b, 1'b1);
            end
        end else begin
            pr_phase = PH_IDLE;
            if (b >= GB_LEAD_LO && b <= GB_LEAD_HI) begin
                pr_lead  = b;
                pr_phase = PH_LEAD;
            end
        end
    endtask

    // utf-8: lead E4..E9; the two end leads bound their second and third bytes
    task automatic utf8_step(input logic [7:0] b);
        if (pr_phase == PH_LEAD) begin
            pr_phase  = PH_SECOND;
            pr_check  = CHK_NONE;
            pr_second = b;
            // the lowest lead is E4, the highest E9
            if (pr_lead == U8_LEAD_LO) begin
                if (b < U8_E4_SECOND_MIN)
                    pr_phase = PH_IDLE;
                else if (b == U8_E4_SECOND_MIN)
                    pr_check = CHK_MIN;
            end else if (pr_lead == U8_LEAD_HI) begin
                if (b > U8_E9_SECOND_MAX)
                    pr_phase = PH_IDLE;
                else if (b == U8_E9_SECOND_MAX)
                    pr_check = CHK_MAX;
            end
        end else if (pr_phase == PH_SECOND) begin
            if (!(pr_check == CHK_MIN && b < U8_E4B8_THIRD_MIN) &&
                !(pr_check == CHK_MAX && b > U8_E9BF_THIRD_MAX)) begin
                emit_char(pr_lead, 1'b0);
                emit_char(pr_second, 1'b0);
                emit_char(b, 1'b1);
            end
            pr_phase = PH_IDLE;
            pr_check = CHK_NONE;
        end else begin
            pr_phase = PH_IDLE;
            pr_check = CHK_NONE;
            if (b >= U8_LEAD_LO && b <= U8_LEAD_HI) begin
                pr_lead  = b;
                pr_phase = PH_LEAD;
            end
        end
    endtask

    // results of one byte into step_chars
    task automatic predict_chars(input logic [7:0] b, input logic seg_end);
        step_chars.delete();
        // order mark bytes are counted in both modes, dropped only in utf-8
        if (pr_skip != 2'd0) begin
            pr_skip = pr_skip - 2'd1;
            if (pr_mode == MODE_GB)
                gb_step(b);
        end else if (pr_mode == MODE_UTF8) begin
            utf8_step(b);
        end else begin
            gb_step(b);
        end
        // segment end drops a partial sequence and rearms the order mark
        if (seg_end) begin
            pr_phase = PH_IDLE;
            pr_check = CHK_NONE;
            pr_skip  = BOM_LEN;
        end
    endtask

    task automatic expect_char(input logic [7:0] b, input logic last);
        t_char_out c;
        c.cbyte = b;
        c.clast = last;
        pending_chars = {pending_chars, c};
    endtask

    // one input request, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic seg_end,
                             input logic predicted);
        int gap;
        int i;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = seg_end;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_chars(b, seg_end);
        if (predicted) begin
            for (i = 0; i < step_chars.size(); i++)
                pending_chars = {pending_chars, step_chars[i]};
        end
        @(negedge i_clk);
    endtask

    // wait for an idle block, then write utf8_mode
    task automatic settle_and_write(input logic m);
        s_axis_tvalid = 1'b0;
        while (pending_chars.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        pr_mode  = m;
        pr_phase = PH_IDLE;
        pr_check = CHK_NONE;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // value in lo..hi, with the two ends drawn often
    function automatic logic [7:0] near_edge(input logic [7:0] lo, input logic [7:0] hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return 8'($urandom_range(int'(lo), int'(hi)));
        endcase
    endfunction

    task automatic plan_byte(input logic [7:0] b);
        t_byte_in s;
        s.data    = b;
        s.seg_end = 1'b0;
        seg_plan = {seg_plan, s};
    endtask

    // one character, a broken sequence or a noise byte
    task automatic plan_chunk(input logic u8);
        logic [7:0] lead;
        logic [7:0] second;
        int kind;
        kind = $urandom_range(0, 9);
        if (!u8) begin
            if (kind <= 5) begin
                plan_byte(near_edge(GB_LEAD_LO, GB_LEAD_HI));
                plan_byte(near_edge(GB_TRAIL_LO, GB_TRAIL_HI));
            end else if (kind <= 7) begin
                plan_byte(near_edge(GB_LEAD_LO, GB_LEAD_HI));
                if ($urandom_range(0, 1) != 0)
                    plan_byte(8'hFF);
                else
                    plan_byte(near_edge(8'h00, GB_TRAIL_LO - 8'd1));
            end else begin
                plan_byte(8'($urandom_range(0, 255)));
            end
        end else if (kind <= 5) begin
            lead = near_edge(U8_LEAD_LO, U8_LEAD_HI);
            if (lead == U8_LEAD_LO)
                second = near_edge(U8_E4_SECOND_MIN, 8'hFF);
            else if (lead == U8_LEAD_HI)
                second = near_edge(8'h00, U8_E9_SECOND_MAX);
            else
                second = 8'($urandom_range(0, 255));
            plan_byte(lead);
            plan_byte(second);
            if (lead == U8_LEAD_LO && second == U8_E4_SECOND_MIN)
                plan_byte(near_edge(U8_E4B8_THIRD_MIN, 8'hFF));
            else if (lead == U8_LEAD_HI && second == U8_E9_SECOND_MAX)
                plan_byte(near_edge(8'h00, U8_E9BF_THIRD_MAX));
            else
                plan_byte(8'($urandom_range(0, 255)));
        end else if (kind <= 7) begin
            // second or third byte just outside its bound
            case ($urandom_range(0, 3))
                0: begin
                    plan_byte(U8_LEAD_LO);
                    plan_byte(near_edge(8'h00, U8_E4_SECOND_MIN - 8'd1));
                end
                1: begin
                    plan_byte(U8_LEAD_HI);
                    plan_byte(near_edge(U8_E9_SECOND_MAX + 8'd1, 8'hFF));
                end
                2: begin
                    plan_byte(U8_LEAD_LO);
                    plan_byte(U8_E4_SECOND_MIN);
                    plan_byte(near_edge(8'h00, U8_E4B8_THIRD_MIN - 8'd1));
                end
                default: begin
                    plan_byte(U8_LEAD_HI);
                    plan_byte(U8_E9_SECOND_MAX);
                    plan_byte(near_edge(U8_E9BF_THIRD_MAX + 8'd1, 8'hFF));
                end
            endcase
        end else begin
            plan_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // one segment into seg_plan, last byte flagged
    task automatic plan_segment(input logic u8);
        int n_chunks;
        int len;
        t_byte_in tail;
        n_chunks = $urandom_range(1, 6);
        if ($urandom_range(0, 7) == 0) begin
            // segment no longer than the order mark
            len = $urandom_range(1, 3);
            plan_chunk(u8);
            while (seg_plan.size() > len) tail = seg_plan.pop_back();
        end else begin
            if (u8 && $urandom_range(0, 1) != 0) begin
                plan_byte(BOM_B0);
                plan_byte(BOM_B1);
                plan_byte(BOM_B2);
            end
            repeat (n_chunks) plan_chunk(u8);
            // sequence cut off by the segment end
            if ($urandom_range(0, 3) == 0) begin
                if (u8) begin
                    plan_byte(near_edge(U8_LEAD_LO, U8_LEAD_HI));
                    if ($urandom_range(0, 1) != 0)
                        plan_byte(8'($urandom_range(0, 255)));
                end else begin
                    plan_byte(near_edge(GB_LEAD_LO, GB_LEAD_HI));
                end
            end
        end
        tail = seg_plan.pop_back();
        tail.seg_end = 1'b1;
        seg_plan = {seg_plan, tail};
    endtask

    // random segments; a phase may stop in the middle of one
    task automatic run_random_phase(input logic m, input int n_items);
        t_byte_in nxt;
        int sent;
        sent = 0;
        seg_plan.delete();
        while (sent < n_items) begin
            if (seg_plan.size() == 0)
                plan_segment(m);
            nxt = seg_plan.pop_front();
            send_byte(nxt.data, nxt.seg_end, 1'b1);
            sent++;
        end
    endtask

    // result receiver with random stalls and an occasional long hold-off
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (rx_hold_cycles != 0) begin
                m_axis_tready = 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle ? $urandom_range(0, 4) : 0;
            if (gap != 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_char_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected result", 9'h000, {m_axis_tdata, m_axis_tlast});
            end else begin
                want = pending_chars.pop_front();
                if (want.cbyte !== m_axis_tdata)
                    report_mismatch("char_byte", {1'b0, want.cbyte}, {1'b0, m_axis_tdata});
                if (want.clast !== m_axis_tlast)
                    report_mismatch("char_last", {8'h00, want.clast}, {8'h00, m_axis_tlast});
            end
        end
    end

    // stimulus
    initial begin
        int r;
        int ph;
        t_dir_row row;
        logic cur_mode;
        logic ph_mode;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = MODE_GB;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, starting in the reset mode
        cur_mode = MODE_GB;
        for (r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            if (row.mode != cur_mode) begin
                settle_and_write(row.mode);
                cur_mode = row.mode;
            end
            if (row.typed) begin
                if (row.n_chars >= 2'd1)
                    expect_char(row.e0, row.n_chars == 2'd1);
                if (row.n_chars >= 2'd2)
                    expect_char(row.e1, row.n_chars == 2'd2);
                if (row.n_chars == 2'd3)
                    expect_char(row.e2, 1'b1);
            end
            send_byte(row.data, row.seg_end, !row.typed);
        end

        // random phases, alternating encodings
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            ph_mode = (ph % 2 == 0) ? MODE_GB : MODE_UTF8;
            settle_and_write(ph_mode);
            tx_idle = (ph != 2);
            rx_idle = (ph != 2) && (ph != 5);
            // fill the result queue so that input requests stall
            if (ph == 1 || ph == 4)
                rx_hold_cycles = HOLD_CYCLES;
            run_random_phase(ph_mode, PHASE_ITEMS);
        end
        s_axis_tvalid = 1'b0;

        // drain
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASS cjk_byte_extractor");
        end else begin
            $display("FAIL cjk_byte_extractor");
        end
        $finish;
    end

endmodule
